[hdl/palette_pixel_access_unit_macros.svh]
// Assertion macros for the palette pixel access unit.
`ifndef PALETTE_PIXEL_ACCESS_UNIT_MACROS_SVH
`define PALETTE_PIXEL_ACCESS_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Consequent must hold in the same cycle as the antecedent.
`define PPAU_ASSERT_SAME(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("ppau assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define PPAU_ASSERT_NEXT(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("ppau assertion failed");

`else

`define PPAU_ASSERT_SAME(name, ck, rs, ante, cons)
`define PPAU_ASSERT_NEXT(name, ck, rs, ante, cons)

`endif

`endif

[hdl/ppau_pkg.sv]
// Shared types and constants of the palette pixel access unit.
package ppau_pkg;

  // Default store sizes
  localparam int IMAGE_WORDS_DEF     = 16384;
  localparam int PALETTE_ENTRIES_DEF = 256;

  // Field widths
  localparam int CMD_W    = 2;
  localparam int COORD_W  = 12;
  localparam int COLOR_W  = 32;
  localparam int ENTRY_W  = 8;
  localparam int STATUS_W = 2;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int STRIDE_W   = 16;
  localparam int PSIZE_W    = 9;

  // Address arithmetic: y * stride, column term, full byte address
  localparam int PROD_W = COORD_W + STRIDE_W;
  localparam int XT_W   = COORD_W + 2;
  localparam int BA_W   = PROD_W + 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_LOAD  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    DEPTH_ONE    = 2'd0,
    DEPTH_EIGHT  = 2'd1,
    DEPTH_THIRTY = 2'd2,
    DEPTH_OTHER  = 2'd3
  } depth_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_NOMATCH = 2'd1,
    ST_DEPTH   = 2'd2,
    ST_RANGE   = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEPTH_MODE = 2'd0,
    CFG_MONO_LSB   = 2'd1,
    CFG_ROW_STRIDE = 2'd2,
    CFG_PAL_SIZE   = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ADDR,
    S_EXEC,
    S_RDATA,
    S_PWAIT,
    S_SEARCH,
    S_FINISH
  } state_t;

  // Register reset values
  localparam logic [STRIDE_W-1:0] STRIDE_RST = 16'd4096;
  localparam logic [PSIZE_W-1:0]  PSIZE_RST  = 9'd2;

endpackage

[hdl/ppau_req_if.sv]
// Command channel of the palette pixel access unit.
interface ppau_req_if;
  logic                             valid;
  logic                             ready;
  logic [ppau_pkg::CMD_W-1:0]       command;
  logic [ppau_pkg::COORD_W-1:0]     x_coord;
  logic [ppau_pkg::COORD_W-1:0]     y_coord;
  logic [ppau_pkg::COLOR_W-1:0]     color_value;
  logic [ppau_pkg::ENTRY_W-1:0]     entry_index;

  modport source (
    output valid, command, x_coord, y_coord, color_value, entry_index,
    input  ready
  );
  modport sink (
    input  valid, command, x_coord, y_coord, color_value, entry_index,
    output ready
  );
endinterface

[hdl/ppau_rsp_if.sv]
// Result channel of the palette pixel access unit.
interface ppau_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [ppau_pkg::COLOR_W-1:0]     pixel_color;
  logic [ppau_pkg::STATUS_W-1:0]    status;

  modport source (
    output valid, pixel_color, status,
    input  ready
  );
  modport sink (
    input  valid, pixel_color, status,
    output ready
  );
endinterface

[hdl/palette_pixel_access_unit.sv]
// Indexed-color pixel access unit: image store, palette, command sequencer.
//
// After reset the unit sweeps the image store to zero, one word per cycle, over
// all IMAGE_WORDS words (16384 by default); no command is taken during the sweep,
// configuration writes are. Commands then run one at a time through a sequencer
// around two synchronous memories (image store and palette), each with one write
// port and one registered read port. Every command passes through the address,
// execute and finish states; a raw 32-bit read adds a data state, a read through
// the palette adds a data state and a palette wait, and a one- or eight-bit write
// adds a palette search that compares entries up to the first match (all of them
// when none matches): the palette search reads one entry per cycle through the
// palette port. The result waits in an output register and the next command can
// be taken while it does; if the previous result is still waiting when the next
// one is ready, the sequencer holds until it is taken. Configuration must be
// written only while the unit is idle.
`include "palette_pixel_access_unit_macros.svh"

module palette_pixel_access_unit #(
  parameter int IMAGE_WORDS     = ppau_pkg::IMAGE_WORDS_DEF,
  parameter int PALETTE_ENTRIES = ppau_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [ppau_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [ppau_pkg::CFG_DATA_W-1:0] wr_data,
  ppau_req_if.sink                        req,
  ppau_rsp_if.source                      rsp
);

  localparam int IW      = (IMAGE_WORDS > 1) ? $clog2(IMAGE_WORDS) : 1;
  localparam int PW      = $clog2(PALETTE_ENTRIES);
  localparam int BA_W    = ppau_pkg::BA_W;
  localparam int PROD_W  = ppau_pkg::PROD_W;
  localparam int XT_W    = ppau_pkg::XT_W;
  localparam int PSIZE_W = ppau_pkg::PSIZE_W;
  localparam logic [IW-1:0]      CLR_LAST = IW'(IMAGE_WORDS - 1);
  localparam logic [BA_W-3:0]    WORD_LIM = (BA_W-2)'(IMAGE_WORDS);
  localparam logic [PSIZE_W-1:0] PAL_N    = PSIZE_W'(PALETTE_ENTRIES);

  // Configuration registers
  ppau_pkg::depth_t                depth_mode;
  logic                            mono_lsb_first;
  logic [ppau_pkg::STRIDE_W-1:0]   row_stride;
  logic [PSIZE_W-1:0]              palette_size;

  // Sequencer and latched command
  ppau_pkg::state_t                state, state_next;
  logic [IW-1:0]                   clr_idx;
  ppau_pkg::cmd_t                  cmd_q;
  logic [ppau_pkg::COORD_W-1:0]    x_q;
  logic [ppau_pkg::COLOR_W-1:0]    color_q;
  logic [ppau_pkg::ENTRY_W-1:0]    entry_q;
  logic [PROD_W-1:0]               prod;

  // Address stage
  logic [XT_W-1:0]                 xterm;
  logic [BA_W-1:0]                 baddr;
  logic [IW-1:0]                   word_idx;
  logic                            in_range;
  logic [1:0]                      lane;
  logic [2:0]                      bitpos;

  // Memories
  logic [31:0]                     img_mem [IMAGE_WORDS];
  logic [31:0]                     pal_mem [PALETTE_ENTRIES];
  logic [PALETTE_ENTRIES-1:0]      pal_vld;
  logic [31:0]                     img_q;
  logic [31:0]                     pal_q;
  logic                            pal_ok;
  logic [31:0]                     pal_color;
  logic                            img_we;
  logic [IW-1:0]                   img_waddr;
  logic [31:0]                     img_wdata;
  logic                            pal_we;
  logic [PSIZE_W-1:0]              pal_raddr;
  logic [PSIZE_W-1:0]              pal_count;

  // Palette search
  logic [PSIZE_W-1:0]              srch_idx;
  logic [PSIZE_W-1:0]              srch_tag;
  logic                            srch_pend;
  logic                            srch_issue;
  logic                            srch_found;

  // Pixel data path
  logic [31:0]                     lane_word;
  logic [7:0]                      pix_byte;
  logic [7:0]                      new_byte;
  logic [31:0]                     lane_mask;
  logic [31:0]                     mod_word;

  // Result and output register
  logic                            res_load;
  logic [31:0]                     res_color_next;
  ppau_pkg::status_t               res_status_next;
  logic [31:0]                     res_color;
  ppau_pkg::status_t               res_status;
  logic                            out_valid;
  logic [31:0]                     out_color;
  ppau_pkg::status_t               out_status;
  logic                            out_free;

  assign req.ready       = (state == ppau_pkg::S_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.pixel_color = out_color;
  assign rsp.status      = out_status;
  assign out_free        = !out_valid || rsp.ready;

  // Effective palette size
  assign pal_count = (palette_size > PAL_N) ? PAL_N : palette_size;
  assign pal_color = pal_ok ? pal_q : 32'd0;

  // Byte address of the pixel
  always_comb begin
    case (depth_mode)
      ppau_pkg::DEPTH_ONE:   xterm = XT_W'(x_q >> 3);
      ppau_pkg::DEPTH_EIGHT: xterm = XT_W'(x_q);
      default:               xterm = {x_q, 2'b00};
    endcase
    baddr = BA_W'(prod) + BA_W'(xterm);
  end

  // Pick the pixel byte and build the written-back word
  always_comb begin
    lane_word = img_q >> {lane, 3'b000};
    pix_byte  = lane_word[7:0];
    new_byte  = pix_byte;
    if (depth_mode == ppau_pkg::DEPTH_ONE) begin
      new_byte[bitpos] = (srch_tag != '0);
    end else begin
      new_byte = srch_tag[7:0];
    end
    lane_mask = 32'hFF << {lane, 3'b000};
    mod_word  = (img_q & ~lane_mask) | ({24'd0, new_byte} << {lane, 3'b000});
  end

  assign srch_issue = (srch_idx < pal_count);
  assign srch_found = srch_pend && (pal_color == color_q);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ppau_pkg::S_CLEAR: begin
        if (clr_idx == CLR_LAST) state_next = ppau_pkg::S_IDLE;
      end
      ppau_pkg::S_IDLE: begin
        if (req.valid) state_next = ppau_pkg::S_ADDR;
      end
      ppau_pkg::S_ADDR: state_next = ppau_pkg::S_EXEC;
      ppau_pkg::S_EXEC: begin
        if (cmd_q != ppau_pkg::CMD_READ && cmd_q != ppau_pkg::CMD_WRITE) begin
          state_next = ppau_pkg::S_FINISH;
        end else if (cmd_q == ppau_pkg::CMD_WRITE && depth_mode == ppau_pkg::DEPTH_OTHER) begin
          state_next = ppau_pkg::S_FINISH;
        end else if (!in_range) begin
          state_next = ppau_pkg::S_FINISH;
        end else if (cmd_q == ppau_pkg::CMD_READ) begin
          state_next = ppau_pkg::S_RDATA;
        end else if (depth_mode == ppau_pkg::DEPTH_THIRTY) begin
          state_next = ppau_pkg::S_FINISH;
        end else begin
          state_next = ppau_pkg::S_SEARCH;
        end
      end
      ppau_pkg::S_RDATA: begin
        if (depth_mode == ppau_pkg::DEPTH_ONE || depth_mode == ppau_pkg::DEPTH_EIGHT) begin
          state_next = ppau_pkg::S_PWAIT;
        end else begin
          state_next = ppau_pkg::S_FINISH;
        end
      end
      ppau_pkg::S_PWAIT: state_next = ppau_pkg::S_FINISH;
      ppau_pkg::S_SEARCH: begin
        if (srch_found || !srch_issue) state_next = ppau_pkg::S_FINISH;
      end
      ppau_pkg::S_FINISH: begin
        if (out_free) state_next = ppau_pkg::S_IDLE;
      end
      default: state_next = ppau_pkg::S_IDLE;
    endcase
  end

  // Memory strobes and result capture
  always_comb begin
    img_we          = 1'b0;
    img_waddr       = word_idx;
    img_wdata       = mod_word;
    pal_we          = 1'b0;
    pal_raddr       = '0;
    res_load        = 1'b0;
    res_color_next  = 32'd0;
    res_status_next = ppau_pkg::ST_DONE;
    case (state)
      ppau_pkg::S_CLEAR: begin
        img_we    = 1'b1;
        img_waddr = clr_idx;
        img_wdata = 32'd0;
      end
      ppau_pkg::S_EXEC: begin
        res_load = 1'b1;
        if (cmd_q == ppau_pkg::CMD_LOAD) begin
          pal_we = ({1'b0, entry_q} < PAL_N);
        end else if (cmd_q != ppau_pkg::CMD_READ && cmd_q != ppau_pkg::CMD_WRITE) begin
          res_status_next = ppau_pkg::ST_DONE;
        end else if (cmd_q == ppau_pkg::CMD_WRITE && depth_mode == ppau_pkg::DEPTH_OTHER) begin
          res_status_next = ppau_pkg::ST_DEPTH;
        end else if (!in_range) begin
          res_status_next = ppau_pkg::ST_RANGE;
        end else if (cmd_q == ppau_pkg::CMD_WRITE && depth_mode == ppau_pkg::DEPTH_THIRTY) begin
          img_we    = 1'b1;
          img_wdata = color_q;
        end
      end
      ppau_pkg::S_RDATA: begin
        res_load       = 1'b1;
        res_color_next = img_q;
        if (depth_mode == ppau_pkg::DEPTH_ONE) begin
          pal_raddr = PSIZE_W'(pix_byte[bitpos]);
        end else begin
          pal_raddr = {1'b0, pix_byte};
        end
      end
      ppau_pkg::S_PWAIT: begin
        res_load       = 1'b1;
        res_color_next = pal_color;
      end
      ppau_pkg::S_SEARCH: begin
        pal_raddr = srch_idx;
        if (srch_found) begin
          img_we   = 1'b1;
          res_load = 1'b1;
        end else if (!srch_issue) begin
          res_load        = 1'b1;
          res_status_next = ppau_pkg::ST_NOMATCH;
        end
      end
      default: begin
        res_load = 1'b0;
      end
    endcase
  end

  // Control and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ppau_pkg::S_CLEAR;
      clr_idx        <= '0;
      pal_vld        <= '0;
      out_valid      <= 1'b0;
      srch_pend      <= 1'b0;
      depth_mode     <= ppau_pkg::DEPTH_THIRTY;
      mono_lsb_first <= 1'b0;
      row_stride     <= ppau_pkg::STRIDE_RST;
      palette_size   <= ppau_pkg::PSIZE_RST;
    end else begin
      state <= state_next;

      // Configuration writes
      if (wr_en) begin
        case (ppau_pkg::cfg_reg_t'(wr_index))
          ppau_pkg::CFG_DEPTH_MODE: depth_mode     <= ppau_pkg::depth_t'(wr_data[1:0]);
          ppau_pkg::CFG_MONO_LSB:   mono_lsb_first <= wr_data[0];
          ppau_pkg::CFG_ROW_STRIDE: row_stride     <= wr_data;
          ppau_pkg::CFG_PAL_SIZE:   palette_size   <= wr_data[PSIZE_W-1:0];
          default:                  row_stride     <= row_stride;
        endcase
      end

      // Advance the clearing sweep
      if (state == ppau_pkg::S_CLEAR) clr_idx <= clr_idx + 1'b1;

      // Mark loaded palette entries
      if (pal_we) pal_vld[entry_q[PW-1:0]] <= 1'b1;

      // Palette search pipeline: issue one entry, compare it in the cycle after
      if (state == ppau_pkg::S_EXEC) begin
        srch_idx  <= '0;
        srch_pend <= 1'b0;
      end else if (state == ppau_pkg::S_SEARCH) begin
        srch_pend <= srch_issue;
        srch_tag  <= srch_idx;
        if (srch_issue) srch_idx <= srch_idx + 1'b1;
      end

      // Output register: load from the finished item, else drop when taken
      if (state == ppau_pkg::S_FINISH && out_free) begin
        out_valid  <= 1'b1;
        out_color  <= res_color;
        out_status <= res_status;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end

    // Latch the accepted item and form y times stride
    if (req.valid && req.ready) begin
      cmd_q   <= ppau_pkg::cmd_t'(req.command);
      x_q     <= req.x_coord;
      color_q <= req.color_value;
      entry_q <= req.entry_index;
      prod    <= PROD_W'(req.y_coord) * PROD_W'(row_stride);
    end

    // Hold the word address and pixel position
    if (state == ppau_pkg::S_ADDR) begin
      word_idx <= baddr[IW+1:2];
      in_range <= (baddr[BA_W-1:2] < WORD_LIM);
      lane     <= baddr[1:0];
      bitpos   <= mono_lsb_first ? x_q[2:0] : ~x_q[2:0];
    end

    if (res_load) begin
      res_color  <= res_color_next;
      res_status <= res_status_next;
    end

    pal_ok <= (pal_raddr < pal_count) && pal_vld[pal_raddr[PW-1:0]];
  end

  // Image store: one write port, registered read of the current word
  always_ff @(posedge clk) begin
    if (img_we) img_mem[img_waddr] <= img_wdata;
    img_q <= img_mem[word_idx];
  end

  // Palette store: written by load commands, registered read
  always_ff @(posedge clk) begin
    if (pal_we) pal_mem[entry_q[PW-1:0]] <= color_q;
    pal_q <= pal_mem[pal_raddr[PW-1:0]];
  end

  `PPAU_ASSERT_NEXT(a_accept_to_addr, clk, rst, req.valid && req.ready, state == ppau_pkg::S_ADDR)
  `PPAU_ASSERT_SAME(a_img_write_in_range, clk, rst, img_we && (state != ppau_pkg::S_CLEAR), in_range)
  `PPAU_ASSERT_SAME(a_search_bound, clk, rst, state == ppau_pkg::S_SEARCH, srch_idx <= pal_count)
  `PPAU_ASSERT_SAME(a_result_from_finish, clk, rst, $rose(out_valid), $past(state) == ppau_pkg::S_FINISH)

endmodule

[dv/tb_palette_pixel_access_unit.sv]
// Self-checking testbench for the palette pixel access unit: directed table, then random phases.
`timescale 1ns / 100ps

module tb_palette_pixel_access_unit;
  import ppau_pkg::*;

  localparam int unsigned TARGET_ITEMS = 1200;
  localparam int unsigned MAX_GAP      = 13;
  localparam int unsigned IDLE_PAUSE   = 8;
  localparam int unsigned TAIL_CYCLES  = 40;
  localparam int unsigned HOLD_AT      = 300;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COLOR_W-1:0] color;
    logic [ENTRY_W-1:0] entry;
  } pixel_cmd_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    status_t            status;
  } pixel_result_t;

  // One line of the directed table: a register write or an item
  typedef struct {
    bit                    is_reg;
    cfg_reg_t              reg_sel;
    logic [CFG_DATA_W-1:0] reg_val;
    pixel_cmd_t            item;
    bit                    typed;
    pixel_result_t         want;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  wr_en;
  logic [CFG_IDX_W-1:0]  wr_index;
  logic [CFG_DATA_W-1:0] wr_data;

  ppau_req_if req_ch ();
  ppau_rsp_if rsp_ch ();

  palette_pixel_access_unit dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .req      (req_ch),
    .rsp      (rsp_ch)
  );

  always #4 clk = ~clk;

  // Shadow copy of the stores and registers
  logic [COLOR_W-1:0]  image_words    [IMAGE_WORDS_DEF];
  logic [COLOR_W-1:0]  palette_colors [PALETTE_ENTRIES_DEF];
  depth_t              cur_depth;
  logic                cur_lsb_first;
  logic [STRIDE_W-1:0] cur_stride;
  logic [PSIZE_W-1:0]  cur_pal_size;

  pixel_result_t pending_results [$];
  int unsigned   error_count   = 0;
  int unsigned   checked_count = 0;
  bit            rx_steady     = 1'b0;

  function automatic int unsigned palette_count();
    return (cur_pal_size > PALETTE_ENTRIES_DEF) ? PALETTE_ENTRIES_DEF : int'(cur_pal_size);
  endfunction

  function automatic logic [COLOR_W-1:0] palette_lookup(int unsigned idx);
    return (idx < palette_count()) ? palette_colors[idx] : '0;
  endfunction

  // Compute the result of one item and update the shadow stores
  function automatic pixel_result_t predict_access(pixel_cmd_t c);
    pixel_result_t r;
    logic [63:0]   addr;
    int unsigned   word_idx;
    int unsigned   bit_pos;
    int unsigned   sh;
    int unsigned   hit;
    int unsigned   i;
    bit            found;
    logic [7:0]    pix_byte;
    r.color  = '0;
    r.status = ST_DONE;
    bit_pos  = 0;
    hit      = 0;
    found    = 1'b0;
    if (c.cmd == CMD_LOAD) begin
      palette_colors[c.entry] = c.color;
    end else if (c.cmd == CMD_READ || c.cmd == CMD_WRITE) begin
      addr = 64'(c.y) * 64'(cur_stride);
      case (cur_depth)
        DEPTH_ONE: begin
          addr    = addr + 64'(c.x >> 3);
          bit_pos = cur_lsb_first ? int'(c.x[2:0]) : 7 - int'(c.x[2:0]);
        end
        DEPTH_EIGHT: addr = addr + 64'(c.x);
        default:     addr = (addr + 4 * 64'(c.x)) & ~64'd3;
      endcase
      if (c.cmd == CMD_WRITE && cur_depth == DEPTH_OTHER) begin
        r.status = ST_DEPTH;
      end else if ((addr >> 2) >= 64'(IMAGE_WORDS_DEF)) begin
        r.status = ST_RANGE;
      end else begin
        word_idx = int'(addr >> 2);
        sh       = 8 * int'(addr[1:0]);
        pix_byte = image_words[word_idx][sh +: 8];
        if (c.cmd == CMD_READ) begin
          case (cur_depth)
            DEPTH_ONE:   r.color = palette_lookup(pix_byte[bit_pos]);
            DEPTH_EIGHT: r.color = palette_lookup(pix_byte);
            default:     r.color = image_words[word_idx];
          endcase
        end else if (cur_depth == DEPTH_THIRTY) begin
          image_words[word_idx] = c.color;
        end else begin
          // First matching palette entry wins
          for (i = 0; i < palette_count(); i++) begin
            if (!found && palette_colors[i] == c.color) begin
              found = 1'b1;
              hit   = i;
            end
          end
          if (!found) begin
            r.status = ST_NOMATCH;
          end else begin
            if (cur_depth == DEPTH_ONE) pix_byte[bit_pos] = (hit > 0);
            else pix_byte = 8'(hit);
            image_words[word_idx][sh +: 8] = pix_byte;
          end
        end
      end
    end
    return r;
  endfunction

  function automatic plan_row_t cmd_row(logic [CMD_W-1:0] cmd, int unsigned x, int unsigned y,
                                        logic [COLOR_W-1:0] color, logic [ENTRY_W-1:0] entry);
    plan_row_t row;
    row.is_reg     = 1'b0;
    row.reg_sel    = CFG_DEPTH_MODE;
    row.reg_val    = '0;
    row.item.cmd   = cmd;
    row.item.x     = COORD_W'(x);
    row.item.y     = COORD_W'(y);
    row.item.color = color;
    row.item.entry = entry;
    row.typed      = 1'b0;
    row.want       = '0;
    return row;
  endfunction

  function automatic plan_row_t with_result(plan_row_t row, logic [COLOR_W-1:0] color,
                                            status_t status);
    row.typed       = 1'b1;
    row.want.color  = color;
    row.want.status = status;
    return row;
  endfunction

  function automatic plan_row_t reg_row(cfg_reg_t sel, logic [CFG_DATA_W-1:0] val);
    plan_row_t row;
    row         = cmd_row(CMD_READ, 0, 0, '0, '0);
    row.is_reg  = 1'b1;
    row.reg_sel = sel;
    row.reg_val = val;
    return row;
  endfunction

  // Write one register; the caller drops wr_en after the last write
  task automatic write_reg(cfg_reg_t sel, logic [CFG_DATA_W-1:0] val);
    wr_en    <= 1'b1;
    wr_index <= sel;
    wr_data  <= val;
    @(posedge clk);
    case (sel)
      CFG_DEPTH_MODE: cur_depth     = depth_t'(val[1:0]);
      CFG_MONO_LSB:   cur_lsb_first = val[0];
      CFG_ROW_STRIDE: cur_stride    = val;
      CFG_PAL_SIZE:   cur_pal_size  = val[PSIZE_W-1:0];
      default:        cur_stride    = cur_stride;
    endcase
  endtask

  // Offer one item after a gap; valid stays high when the next gap is zero
  task automatic send_cmd(pixel_cmd_t c, int unsigned gap, bit typed, pixel_result_t want);
    pixel_result_t predicted;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.command     <= c.cmd;
    req_ch.x_coord     <= c.x;
    req_ch.y_coord     <= c.y;
    req_ch.color_value <= c.color;
    req_ch.entry_index <= c.entry;
    do @(posedge clk); while (!req_ch.ready);
    predicted = predict_access(c);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // Drop valid and wait until every result is back and the unit has settled
  task automatic drain_to_idle();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (IDLE_PAUSE) @(posedge clk);
  endtask

  // Result side: random stalls, one long hold-off, compare with oldest expectation
  initial begin : result_sink
    pixel_result_t exp_res;
    int unsigned   stall;
    bit            held;
    held         = 1'b0;
    rsp_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && checked_count >= HOLD_AT) begin
        stall = HOLD_CYCLES;
        held  = 1'b1;
      end else begin
        stall = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, expected none, actual color %h status %0d",
                 $time, rsp_ch.pixel_color, rsp_ch.status);
      end else begin
        exp_res = pending_results.pop_front();
        if (rsp_ch.pixel_color !== exp_res.color) begin
          error_count++;
          $display("%0t: pixel_color expected %h actual %h",
                   $time, exp_res.color, rsp_ch.pixel_color);
        end
        if (rsp_ch.status !== exp_res.status) begin
          error_count++;
          $display("%0t: status expected %0d actual %0d",
                   $time, exp_res.status, rsp_ch.status);
        end
      end
      checked_count++;
    end
  end

  initial begin : watchdog
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    plan_row_t             plan [$];
    pixel_cmd_t            c;
    pixel_result_t         none;
    logic [COLOR_W-1:0]    color_pool [8];
    logic [1:0]            pdepth;
    logic                  plsb;
    logic [CFG_DATA_W-1:0] pstride;
    logic [CFG_DATA_W-1:0] psize;
    int unsigned           issued;
    int unsigned           phase;
    int unsigned           n_items;
    int unsigned           k;
    int unsigned           roll;
    int unsigned           gap;
    bit                    tx_steady;

    // Known values on every input from time zero
    rst                = 1'b1;
    wr_en              = 1'b0;
    wr_index           = CFG_DEPTH_MODE;
    wr_data            = '0;
    req_ch.valid       = 1'b0;
    req_ch.command     = CMD_READ;
    req_ch.x_coord     = '0;
    req_ch.y_coord     = '0;
    req_ch.color_value = '0;
    req_ch.entry_index = '0;
    none               = '0;

    // Shadow state after reset
    foreach (image_words[i]) image_words[i] = '0;
    foreach (palette_colors[i]) palette_colors[i] = '0;
    cur_depth     = DEPTH_THIRTY;
    cur_lsb_first = 1'b0;
    cur_stride    = STRIDE_RST;
    cur_pal_size  = PSIZE_RST;

    // Directed table: reset values, range edges, unused command, palette loads
    plan.push_back(with_result(cmd_row(CMD_READ, 0, 0, '0, '0), '0, ST_DONE));
    plan.push_back(with_result(cmd_row(CMD_READ, 4095, 4095, '0, '0), '0, ST_RANGE));
    plan.push_back(with_result(cmd_row(CMD_WRITE, 1023, 15, 32'hFFFF_FFFF, '0), '0, ST_DONE));
    plan.push_back(with_result(cmd_row(CMD_READ, 1023, 15, '0, '0), 32'hFFFF_FFFF, ST_DONE));
    plan.push_back(with_result(cmd_row(CMD_WRITE, 0, 16, '0, '0), '0, ST_RANGE));
    plan.push_back(with_result(cmd_row(CMD_UNUSED, 4095, 4095, 32'hFFFF_FFFF, 8'hFF), '0,
                               ST_DONE));
    plan.push_back(with_result(cmd_row(CMD_LOAD, 0, 0, 32'hFFFF_FFFF, 8'd255), '0, ST_DONE));
    plan.push_back(with_result(cmd_row(CMD_LOAD, 0, 0, 32'h00FF_00FF, 8'd1), '0, ST_DONE));
    plan.push_back(with_result(cmd_row(CMD_LOAD, 0, 0, 32'h8000_0001, 8'd0), '0, ST_DONE));
    // Eight-bit: match, read back, no match, palette size zero and oversized
    plan.push_back(reg_row(CFG_DEPTH_MODE, 16'(DEPTH_EIGHT)));
    plan.push_back(with_result(cmd_row(CMD_WRITE, 5, 0, 32'h00FF_00FF, '0), '0, ST_DONE));
    plan.push_back(with_result(cmd_row(CMD_READ, 5, 0, '0, '0), 32'h00FF_00FF, ST_DONE));
    plan.push_back(with_result(cmd_row(CMD_WRITE, 6, 0, 32'h1111_1111, '0), '0, ST_NOMATCH));
    plan.push_back(cmd_row(CMD_READ, 4095, 0, '0, '0));
    plan.push_back(reg_row(CFG_PAL_SIZE, 16'd0));
    plan.push_back(with_result(cmd_row(CMD_READ, 5, 0, '0, '0), '0, ST_DONE));
    plan.push_back(with_result(cmd_row(CMD_WRITE, 5, 0, 32'h00FF_00FF, '0), '0, ST_NOMATCH));
    plan.push_back(reg_row(CFG_PAL_SIZE, 16'd511));
    plan.push_back(with_result(cmd_row(CMD_WRITE, 7, 0, 32'hFFFF_FFFF, '0), '0, ST_DONE));
    plan.push_back(with_result(cmd_row(CMD_READ, 7, 0, '0, '0), 32'hFFFF_FFFF, ST_DONE));
    // One-bit, MSB first then LSB first; a high index sets the bit
    plan.push_back(reg_row(CFG_DEPTH_MODE, 16'(DEPTH_ONE)));
    plan.push_back(with_result(cmd_row(CMD_WRITE, 0, 0, 32'h00FF_00FF, '0), '0, ST_DONE));
    plan.push_back(with_result(cmd_row(CMD_READ, 0, 0, '0, '0), 32'h00FF_00FF, ST_DONE));
    plan.push_back(with_result(cmd_row(CMD_READ, 1, 0, '0, '0), 32'h8000_0001, ST_DONE));
    plan.push_back(reg_row(CFG_MONO_LSB, 16'd1));
    plan.push_back(with_result(cmd_row(CMD_READ, 7, 0, '0, '0), 32'h00FF_00FF, ST_DONE));
    plan.push_back(cmd_row(CMD_WRITE, 9, 0, 32'hFFFF_FFFF, '0));
    plan.push_back(with_result(cmd_row(CMD_WRITE, 7, 0, 32'h8000_0001, '0), '0, ST_DONE));
    plan.push_back(cmd_row(CMD_READ, 9, 0, '0, '0));
    // Other depth: writes refused, reads return the raw word
    plan.push_back(reg_row(CFG_DEPTH_MODE, 16'(DEPTH_OTHER)));
    plan.push_back(with_result(cmd_row(CMD_WRITE, 0, 0, '0, '0), '0, ST_DEPTH));
    plan.push_back(with_result(cmd_row(CMD_READ, 1023, 15, '0, '0), 32'hFFFF_FFFF, ST_DONE));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Walk the table; registers change only once the unit has gone idle
    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        if (i == 0 || !plan[i-1].is_reg) drain_to_idle();
        write_reg(plan[i].reg_sel, plan[i].reg_val);
        if (i == plan.size() - 1 || !plan[i+1].is_reg) wr_en <= 1'b0;
      end else begin
        send_cmd(plan[i].item, $urandom_range(0, MAX_GAP), plan[i].typed, plan[i].want);
      end
    end

    // Random phases: new register set, color pool and idling style per phase
    issued = 0;
    for (phase = 0; issued < TARGET_ITEMS; phase++) begin
      drain_to_idle();
      plsb = 1'($urandom_range(0, 1));
      case (phase)
        0: begin
          pdepth = DEPTH_ONE;    plsb = 1'b0; pstride = 16'd65532; psize = 16'd256;
        end
        1: begin
          pdepth = DEPTH_EIGHT;  plsb = 1'b1; pstride = 16'd4;     psize = 16'd511;
        end
        2: begin
          pdepth = DEPTH_THIRTY; pstride = 16'($urandom_range(0, 65535)); psize = 16'd0;
        end
        3: begin
          pdepth = DEPTH_OTHER;  pstride = 16'd6; psize = 16'd1;
        end
        default: begin
          pdepth = 2'($urandom_range(0, 3));
          roll   = $urandom_range(0, 9);
          if (roll < 6)       pstride = 16'(4 * $urandom_range(1, 256));
          else if (roll < 8)  pstride = 16'($urandom_range(0, 300));
          else if (roll == 8) pstride = 16'd65532;
          else                pstride = 16'd4;
          roll = $urandom_range(0, 9);
          if (roll < 7)       psize = 16'($urandom_range(1, 16));
          else if (roll == 7) psize = 16'd0;
          else if (roll == 8) psize = 16'd256;
          else                psize = 16'($urandom_range(0, 511));
        end
      endcase
      write_reg(CFG_DEPTH_MODE, 16'(pdepth));
      write_reg(CFG_MONO_LSB, 16'(plsb));
      write_reg(CFG_ROW_STRIDE, pstride);
      write_reg(CFG_PAL_SIZE, psize);
      wr_en <= 1'b0;

      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      color_pool[0] = '0;
      for (k = 1; k < 8; k++) color_pool[k] = $urandom;
      n_items = $urandom_range(20, 60);

      for (k = 0; k < n_items && issued < TARGET_ITEMS; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 12)      c.cmd = CMD_LOAD;
        else if (roll < 50) c.cmd = CMD_WRITE;
        else if (roll < 97) c.cmd = CMD_READ;
        else                c.cmd = CMD_UNUSED;
        // Keep most accesses in a small window so reads hit earlier writes
        if ($urandom_range(0, 99) < 85) begin
          c.x = COORD_W'($urandom_range(0, 63));
          c.y = COORD_W'($urandom_range(0, 3));
        end else begin
          c.x = COORD_W'($urandom_range(0, 4095));
          c.y = COORD_W'($urandom_range(0, 4095));
        end
        c.entry = ($urandom_range(0, 3) == 0) ? ENTRY_W'($urandom_range(0, 255))
                                              : ENTRY_W'($urandom_range(0, 15));
        // Writes mostly carry a color already in the palette
        roll = $urandom_range(0, 9);
        if (c.cmd == CMD_WRITE && roll < 7) c.color = palette_colors[$urandom_range(0, 15)];
        else if (roll < 8)                  c.color = color_pool[$urandom_range(0, 7)];
        else                                c.color = $urandom;
        gap = tx_steady ? 0 : $urandom_range(0, MAX_GAP);
        send_cmd(c, gap, 1'b0, none);
        issued++;
      end
    end

    drain_to_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
